// File: design/ezr_pkg.sv
package ezr_pkg;

  localparam int ANGLE_BITS_DEF    = 16;
  localparam int FRAC_BITS_DEF     = 14;
  localparam int CORDIC_STAGES_DEF = 16;

  // Working precision of the sine/cosine datapath (Q2.30).
  localparam int WORK_BITS = 32;
  localparam int WORK_FRAC = 30;
  localparam logic signed [WORK_BITS-1:0] CORDIC_GAIN = 32'sd652032874;

  typedef struct packed {
    logic signed [15:0] angle_z;
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
  } req_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } rsp_t;

  // Arctangent step table, floor(atan(2^-i) * 2^31 / pi).
  function automatic logic signed [WORK_BITS-1:0] atan_step(input logic [4:0] i);
    logic signed [WORK_BITS-1:0] t;
    case (i)
      5'd0:  t = 32'sh20000000;
      5'd1:  t = 32'sh12E4051D;
      5'd2:  t = 32'sh09FB385B;
      5'd3:  t = 32'sh051111D4;
      5'd4:  t = 32'sh028B0D43;
      5'd5:  t = 32'sh0145D7E1;
      5'd6:  t = 32'sh00A2F61E;
      5'd7:  t = 32'sh00517C55;
      5'd8:  t = 32'sh0028BE53;
      5'd9:  t = 32'sh00145F2E;
      5'd10: t = 32'sh000A2F98;
      5'd11: t = 32'sh000517CC;
      5'd12: t = 32'sh00028BE6;
      5'd13: t = 32'sh000145F3;
      5'd14: t = 32'sh0000A2F9;
      5'd15: t = 32'sh0000517C;
      5'd16: t = 32'sh000028BE;
      5'd17: t = 32'sh0000145F;
      5'd18: t = 32'sh00000A2F;
      5'd19: t = 32'sh00000517;
      5'd20: t = 32'sh0000028B;
      5'd21: t = 32'sh00000145;
      5'd22: t = 32'sh000000A2;
      5'd23: t = 32'sh00000051;
      5'd24: t = 32'sh00000028;
      5'd25: t = 32'sh00000014;
      5'd26: t = 32'sh0000000A;
      5'd27: t = 32'sh00000005;
      5'd28: t = 32'sh00000002;
      5'd29: t = 32'sh00000001;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

// File: design/euler_zxy_to_rotation_matrix_top.sv
// Channel   Direction  Handshake        Payload
// in        input      in_valid/stall   ezr_pkg::req_t (angle_z, angle_x, angle_y)
// out       output     out_valid/stall  ezr_pkg::rsp_t (m00 .. m22)
//
// One request enters per cycle while in_stall is low. Pipeline: one input
// register, the CORDIC stages, quadrant fix, two product stages, sum, output.
// Reset (rst, synchronous) clears only the valid bits of the pipeline.
// A stage advances when it is empty or the stage after it advances, so a stall
// at the output backs up stage by stage without losing or repeating a request.
module euler_zxy_to_rotation_matrix_top #(
  parameter int ANGLE_BITS    = ezr_pkg::ANGLE_BITS_DEF,
  parameter int FRAC_BITS     = ezr_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STAGES = ezr_pkg::CORDIC_STAGES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  ezr_pkg::req_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output ezr_pkg::rsp_t   out_data
);

  localparam int W  = ezr_pkg::WORK_BITS;
  localparam int WF = ezr_pkg::WORK_FRAC;
  localparam int NS = CORDIC_STAGES;
  // Stages: 0 = phase, 1..NS = CORDIC, NS+1 quadrant, NS+2 first products,
  // NS+3 triple products, NS+4 sums, NS+5 output rounding.
  localparam int NP = NS + 6;

  typedef logic signed [W-1:0] w_t;
  typedef struct packed {
    w_t x;
    w_t y;
    w_t z;
    logic [1:0] q;
  } cs_t;

  logic [NP-1:0] vld;
  logic [NP-1:0] adv;

  // Advance chain: a stage loads when it is empty or drains.
  always_comb begin
    adv[NP-1] = !vld[NP-1] || !out_stall;
    for (int i = NP - 2; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign in_stall = !adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = NP - 1; i >= 1; i--) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
    end
  end

  // Input stage: scale the binary angle to a 32-bit phase.
  function automatic cs_t seed(input logic [15:0] a);
    logic [31:0] ph;
    cs_t r;
    ph = 32'($signed(a)) << (32 - ANGLE_BITS);
    r.q = ph[31:30];
    r.z = w_t'({2'b00, ph[29:0]});
    r.x = ezr_pkg::CORDIC_GAIN;
    r.y = '0;
    return r;
  endfunction

  function automatic cs_t rot(input cs_t a, input int k);
    cs_t r;
    w_t t;
    t = ezr_pkg::atan_step(5'(k));
    r.q = a.q;
    if (!a.z[W-1]) begin
      r.x = a.x - (a.y >>> k);
      r.y = a.y + (a.x >>> k);
      r.z = a.z - t;
    end else begin
      r.x = a.x + (a.y >>> k);
      r.y = a.y - (a.x >>> k);
      r.z = a.z + t;
    end
    return r;
  endfunction

  cs_t cz [NS+1];
  cs_t cx [NS+1];
  cs_t cy [NS+1];

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      cz[0] <= seed(in_data.angle_z);
      cx[0] <= seed(in_data.angle_x);
      cy[0] <= seed(in_data.angle_y);
    end
    for (int g = 0; g < NS; g++) begin
      if (adv[g+1]) begin
        cz[g+1] <= rot(cz[g], g);
        cx[g+1] <= rot(cx[g], g);
        cy[g+1] <= rot(cy[g], g);
      end
    end
  end

  // Quadrant fold.
  w_t c_z, s_z, c_x, s_x, c_y, s_y;

  function automatic logic [2*W-1:0] fold(input cs_t a);
    w_t c, s;
    case (a.q)
      2'd0: begin c = a.x;  s = a.y;  end
      2'd1: begin c = -a.y; s = a.x;  end
      2'd2: begin c = -a.x; s = -a.y; end
      default: begin c = a.y; s = -a.x; end
    endcase
    return {c, s};
  endfunction

  always_ff @(posedge clk) begin
    if (adv[NS+1]) begin
      {c_z, s_z} <= fold(cz[NS]);
      {c_x, s_x} <= fold(cx[NS]);
      {c_y, s_y} <= fold(cy[NS]);
    end
  end

  function automatic w_t mul30(input w_t a, input w_t b);
    logic signed [2*W-1:0] p;
    p = (2*W)'(a) * (2*W)'(b) + (64'sd1 <<< (WF - 1));
    return w_t'(p >>> WF);
  endfunction

  // First products; carry the singles needed later.
  w_t p_szsx, p_czsx, p_czcy, p_czsy, p_szcy, p_szsy, p_szcx, p_czcx, p_cxsy, p_cxcy;
  w_t d_sx, d_sy, d_cy;

  always_ff @(posedge clk) begin
    if (adv[NS+2]) begin
      p_szsx <= mul30(s_z, s_x);
      p_czsx <= mul30(c_z, s_x);
      p_czcy <= mul30(c_z, c_y);
      p_czsy <= mul30(c_z, s_y);
      p_szcy <= mul30(s_z, c_y);
      p_szsy <= mul30(s_z, s_y);
      p_szcx <= mul30(s_z, c_x);
      p_czcx <= mul30(c_z, c_x);
      p_cxsy <= mul30(c_x, s_y);
      p_cxcy <= mul30(c_x, c_y);
      d_sx   <= s_x;
      d_sy   <= s_y;
      d_cy   <= c_y;
    end
  end

  // Triple products.
  w_t t_a, t_b, t_c, t_d;
  w_t e_czcy, e_czsy, e_szcy, e_szsy, e_szcx, e_czcx, e_cxsy, e_cxcy, e_sx;

  always_ff @(posedge clk) begin
    if (adv[NS+3]) begin
      t_a <= mul30(p_szsx, d_sy);
      t_b <= mul30(p_szsx, d_cy);
      t_c <= mul30(p_czsx, d_sy);
      t_d <= mul30(p_czsx, d_cy);
      e_czcy <= p_czcy; e_czsy <= p_czsy; e_szcy <= p_szcy; e_szsy <= p_szsy;
      e_szcx <= p_szcx; e_czcx <= p_czcx; e_cxsy <= p_cxsy; e_cxcy <= p_cxcy;
      e_sx   <= d_sx;
    end
  end

  // Sums (one bit of headroom).
  typedef logic signed [W:0] s_t;
  s_t s0, s1, s2, s3, s4, s5, s6, s7, s8;

  always_ff @(posedge clk) begin
    if (adv[NS+4]) begin
      s0 <= s_t'(e_czcy) - s_t'(t_a);
      s1 <= -s_t'(e_szcx);
      s2 <= s_t'(e_czsy) + s_t'(t_b);
      s3 <= s_t'(e_szcy) + s_t'(t_c);
      s4 <= s_t'(e_czcx);
      s5 <= s_t'(e_szsy) - s_t'(t_d);
      s6 <= -s_t'(e_cxsy);
      s7 <= s_t'(e_sx);
      s8 <= s_t'(e_cxcy);
    end
  end

  function automatic logic signed [15:0] to_out(input s_t v);
    localparam int SH = WF - FRAC_BITS;
    logic signed [W+1:0] r;
    logic signed [W+1:0] one;
    one = (W+2)'(1) <<< FRAC_BITS;
    if (SH == 0) begin
      r = (W+2)'(v);
    end else begin
      r = ((W+2)'(v) + ((W+2)'(1) <<< (SH - 1))) >>> SH;
    end
    if (r > one) r = one;
    if (r < -one) r = -one;
    return r[15:0];
  endfunction

  ezr_pkg::rsp_t res;

  always_ff @(posedge clk) begin
    if (adv[NS+5]) begin
      res.m00 <= to_out(s0);
      res.m01 <= to_out(s1);
      res.m02 <= to_out(s2);
      res.m10 <= to_out(s3);
      res.m11 <= to_out(s4);
      res.m12 <= to_out(s5);
      res.m20 <= to_out(s6);
      res.m21 <= to_out(s7);
      res.m22 <= to_out(s8);
    end
  end

  assign out_valid = vld[NP-1];
  assign out_data  = res;

endmodule

// File: design/ezr_checker.sv
module ezr_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input ezr_pkg::rsp_t out_data
);

  // A held result keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed under stall");

  // The input is only held off while the output is held off.
  a_back: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_stall && out_valid)
    else $error("input stalled with free output");

  // Entries m11 and m21 stay within plus or minus one.
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($signed(out_data.m11) <= 16'sd16384 &&
                   $signed(out_data.m11) >= -16'sd16384 &&
                   $signed(out_data.m21) <= 16'sd16384 &&
                   $signed(out_data.m21) >= -16'sd16384))
    else $error("matrix entry out of range");

  // Nothing comes out right after reset.
  a_rst: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result right after reset");

endmodule

bind euler_zxy_to_rotation_matrix_top ezr_checker u_ezr_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

// File: test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // The block keeps no state, so every request simply maps to one matrix.
  // The drain wait at the end allows for the pipeline depth with a margin.
  localparam int PIPE_LATENCY = ezr_pkg::CORDIC_STAGES_DEF + 6;
  localparam int IDLE_LIMIT   = 20000;
  localparam int RANDOM_REQS  = 850;

  localparam longint GAIN_Q30 = 652032874;

  logic           clk;
  logic           rst;
  logic           in_valid;
  logic           in_stall;
  ezr_pkg::req_t  in_data;
  logic           out_valid;
  logic           out_stall;
  ezr_pkg::rsp_t  out_data;

  int    mismatches;
  int    idle_cycles;
  bit    timed_out;

  euler_zxy_to_rotation_matrix_top dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  // Prints one line for a mismatch and counts it.
  task automatic report(input string what);
    $display("ERROR at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  // Floor shift for signed 64-bit values; >>> on a signed longint does that.
  function automatic longint floor_shift(input longint v, input int k);
    return v >>> k;
  endfunction

  function automatic longint round_mul(input longint a, input longint b);
    return floor_shift(a * b + (longint'(1) << 29), 30);
  endfunction

  // Cosine and sine of one binary angle, Q2.30, with the CORDIC in rotation mode.
  function automatic void cordic_cos_sin(input logic [15:0] angle, output longint co,
                                         output longint si);
    logic [31:0] phase;
    logic [1:0]  quad;
    longint      x, y, z, nx, ny, step;
    phase = {angle, 16'h0000};
    quad  = phase[31:30];
    z     = longint'(phase[29:0]);
    x     = GAIN_Q30;
    y     = 0;
    for (int i = 0; i < ezr_pkg::CORDIC_STAGES_DEF; i++) begin
      step = longint'(ezr_pkg::atan_step(i[4:0]));
      if (z >= 0) begin
        nx = x - floor_shift(y, i);
        ny = y + floor_shift(x, i);
        z  = z - step;
      end else begin
        nx = x + floor_shift(y, i);
        ny = y - floor_shift(x, i);
        z  = z + step;
      end
      x = nx;
      y = ny;
    end
    case (quad)
      2'd0: begin co = x;  si = y;  end
      2'd1: begin co = -y; si = x;  end
      2'd2: begin co = -x; si = -y; end
      default: begin co = y; si = -x; end
    endcase
  endfunction

  // Rounds a Q2.30 sum to the output format and clamps it to +/- 1.0.
  function automatic logic [15:0] to_entry(input longint v);
    longint one, r;
    one = longint'(1) << ezr_pkg::FRAC_BITS_DEF;
    r   = floor_shift(v + (longint'(1) << (29 - ezr_pkg::FRAC_BITS_DEF)),
                      30 - ezr_pkg::FRAC_BITS_DEF);
    if (r > one) r = one;
    if (r < -one) r = -one;
    return r[15:0];
  endfunction

  function automatic ezr_pkg::rsp_t rotation_of(input ezr_pkg::req_t a);
    longint        cz, sz, cx, sx, cy, sy, szsx, czsx;
    ezr_pkg::rsp_t m;
    cordic_cos_sin(a.angle_z, cz, sz);
    cordic_cos_sin(a.angle_x, cx, sx);
    cordic_cos_sin(a.angle_y, cy, sy);
    szsx  = round_mul(sz, sx);
    czsx  = round_mul(cz, sx);
    m.m00 = to_entry(round_mul(cz, cy) - round_mul(szsx, sy));
    m.m01 = to_entry(-round_mul(sz, cx));
    m.m02 = to_entry(round_mul(cz, sy) + round_mul(szsx, cy));
    m.m10 = to_entry(round_mul(sz, cy) + round_mul(czsx, sy));
    m.m11 = to_entry(round_mul(cz, cx));
    m.m12 = to_entry(round_mul(sz, sy) - round_mul(czsx, cy));
    m.m20 = to_entry(-round_mul(cx, sy));
    m.m21 = to_entry(sx);
    m.m22 = to_entry(round_mul(cx, cy));
    return m;
  endfunction

  // Holds the matrices still owed by the block, oldest first.
  class matrix_board;
    ezr_pkg::rsp_t owed[$];

    function void note_request(input ezr_pkg::req_t a);
      owed.push_back(rotation_of(a));
    endfunction

    task check_matrix(input ezr_pkg::rsp_t got);
      ezr_pkg::rsp_t want;
      if (owed.size() == 0) begin
        report($sformatf("unexpected matrix %h", got));
        return;
      end
      want = owed.pop_front();
      if (got.m00 !== want.m00) report($sformatf("m00 got %0d want %0d", got.m00, want.m00));
      if (got.m01 !== want.m01) report($sformatf("m01 got %0d want %0d", got.m01, want.m01));
      if (got.m02 !== want.m02) report($sformatf("m02 got %0d want %0d", got.m02, want.m02));
      if (got.m10 !== want.m10) report($sformatf("m10 got %0d want %0d", got.m10, want.m10));
      if (got.m11 !== want.m11) report($sformatf("m11 got %0d want %0d", got.m11, want.m11));
      if (got.m12 !== want.m12) report($sformatf("m12 got %0d want %0d", got.m12, want.m12));
      if (got.m20 !== want.m20) report($sformatf("m20 got %0d want %0d", got.m20, want.m20));
      if (got.m21 !== want.m21) report($sformatf("m21 got %0d want %0d", got.m21, want.m21));
      if (got.m22 !== want.m22) report($sformatf("m22 got %0d want %0d", got.m22, want.m22));
    endtask
  endclass

  matrix_board board;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Angles lean toward the circle's corners, where quadrant handling and
  // the clamp are most likely to go wrong.
  function automatic logic [15:0] pick_angle();
    logic [15:0] corners[6] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                                16'h7FFF, 16'hFFFF};
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return corners[$urandom_range(0, 5)];
    if (roll < 25) return corners[$urandom_range(0, 3)] + 16'($signed($urandom_range(0, 6)) - 3);
    return 16'($urandom);
  endfunction

  // Offers one request and holds it until the block takes it. Valid stays
  // high across requests that follow with no gap.
  task automatic send_request(input ezr_pkg::req_t a);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Accepted requests and results are both observed at the edge itself.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (in_valid && !in_stall) board.note_request(in_data);
      if (out_valid && !out_stall) board.check_matrix(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // The receiver stalls in bursts, with calm stretches in between.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 99) < 30) begin
        out_stall <= 1'b1;
        repeat (pick_gap()) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        repeat ($urandom_range(0, 12)) @(posedge clk);
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  initial begin
    timed_out = 1'b0;
    wait (idle_cycles >= IDLE_LIMIT);
    timed_out = 1'b1;
  end

  initial begin
    ezr_pkg::req_t a;
    logic [15:0]   directed[10];
    int            drain;
    directed   = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h7FFF,
                   16'h8001, 16'hFFFF, 16'h0001, 16'h2000, 16'hE000};
    board      = new();
    mismatches = 0;
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_data    = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    fork
      begin
        // Directed part: quadrant boundaries, extremes and wrap on each angle.
        for (int i = 0; i < 10; i++) begin
          a.angle_z = directed[i];
          a.angle_x = directed[(i + 3) % 10];
          a.angle_y = directed[(i + 7) % 10];
          send_request(a);
        end
        a = '{16'h4000, 16'h4000, 16'h4000}; send_request(a);
        a = '{16'h8000, 16'h8000, 16'h8000}; send_request(a);
        a = '{16'h7FFF, 16'h7FFF, 16'h7FFF}; send_request(a);
        a = '{16'hFFFF, 16'hFFFF, 16'hFFFF}; send_request(a);
        a = '{16'hAAAA, 16'h5555, 16'hAAAA}; send_request(a);
        a = '{16'h5555, 16'hAAAA, 16'h5555}; send_request(a);
        for (int i = 0; i < RANDOM_REQS; i++) begin
          a.angle_z = pick_angle();
          a.angle_x = pick_angle();
          a.angle_y = pick_angle();
          send_request(a);
        end
        in_valid <= 1'b0;
        // Drain: everything owed, then a further wait sized from the pipeline depth for stragglers.
        while (board.owed.size() != 0) @(posedge clk);
        drain = 0;
        while (drain < 4 * PIPE_LATENCY) begin
          @(posedge clk);
          drain++;
        end
      end
      wait (timed_out);
    join_any

    if (timed_out || board.owed.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: sim.f
design/ezr_pkg.sv
design/euler_zxy_to_rotation_matrix_top.sv
design/ezr_checker.sv
test/testbench.sv
